@@ sv/xmodem_crc_receiver_assert.svh @@
// assertion macros for the xmodem crc receiver checker
`ifndef XMODEM_CRC_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define XCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xcr assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define XCR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xcr assertion failed");

`endif

@@ sv/xcr_pkg.sv @@
// shared constants, codes and crc helper for the xmodem crc receiver
`default_nettype none

package xcr_pkg;

	localparam int ADDR_WIDTH = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// packet sizes
	localparam int SMALL_SIZE = 128;
	localparam int LARGE_SIZE = 1024;

	// command codes
	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_TIMEOUT = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// session codes
	localparam logic [1:0] SES_RUN    = 2'd0;
	localparam logic [1:0] SES_DONE   = 2'd1;
	localparam logic [1:0] SES_ABORT  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS = 1'd1;

	// protocol bytes
	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_ETX = 8'h03;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// one byte of crc-16, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/xmodem_crc_receiver.sv @@
// xmodem crc receiver: packet parser, crc check, reply and payload output
// an accepted word is held in the input register, and its result is then written to the result register
// throughput: one input word per cycle while out_ready holds; a cancel takes two output words (CAN CAN)
// the combinational crc update and packet checks between the input and result regs set the rate
// reset: arst_n clears all state at once; base_address 0, max_errors 3, awaiting header
`default_nettype none

module xmodem_crc_receiver (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       cmd,
	input  wire logic [7:0]                       rx_byte,
	// configuration channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [xcr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [xcr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  reply_valid,
	output logic [7:0]                            reply_byte,
	output logic                                  data_valid,
	output logic [7:0]                            data_byte,
	output logic [xcr_pkg::ADDR_WIDTH-1:0]        data_addr,
	output logic                                  packet_done,
	output logic                                  packet_ok,
	output logic [1:0]                            session,
	output logic                                  last
);
	import xcr_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NUMBER,
		PH_COMPL,
		PH_DATA,
		PH_CRC_HI,
		PH_CRC_LO
	} phase_t;

	typedef struct packed {
		logic                  reply_valid;
		logic [7:0]            reply_byte;
		logic                  data_valid;
		logic [7:0]            data_byte;
		logic [ADDR_WIDTH-1:0] data_addr;
		logic                  packet_done;
		logic                  packet_ok;
		logic [1:0]            session;
		logic                  last;
	} result_t;

	// configuration registers
	logic [CFG_DATA_W-1:0] base_address_q;
	logic [7:0]            max_errors_q;

	// input register
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;

	// receiver state
	phase_t                phase_q, phase_d;
	logic [9:0]            byte_count_q, byte_count_d;
	logic                  large_q, large_d;
	logic [7:0]            expected_q, expected_d;
	logic [7:0]            got_number_q, got_number_d;
	logic [7:0]            got_compl_q, got_compl_d;
	logic [15:0]           crc_q, crc_d;
	logic [7:0]            crc_hi_q, crc_hi_d;
	logic [ADDR_WIDTH-1:0] next_addr_q, next_addr_d;
	logic [7:0]            error_count_q, error_count_d;
	logic                  first_seen_q, first_seen_d;
	logic [1:0]            session_q, session_d;

	// result register plus the pending second CAN word
	logic    out_valid_q;
	logic    can2_q;
	result_t out_q;
	result_t res;
	result_t can2_word;

	logic       fire;
	logic       cancel;
	logic       err;
	logic       pkt_good;
	logic [7:0] ec_inc;
	logic [8:0] num_sum;

	// s1 word is processed when the result register is free or draining this cycle with no second CAN word pending
	assign fire      = valid_s1 && (!out_valid_q || (out_ready && !can2_q));
	assign in_ready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	assign ec_inc  = (error_count_q == 8'hFF) ? error_count_q : error_count_q + 8'd1;
	assign num_sum = {1'b0, got_number_q} + {1'b0, got_compl_q};

	// closing word of a cancel keeps the session of the first one
	always_comb begin
		can2_word             = '0;
		can2_word.reply_valid = 1'b1;
		can2_word.reply_byte  = B_CAN;
		can2_word.session     = out_q.session;
		can2_word.last        = 1'b1;
	end

	always_comb begin
		phase_d       = phase_q;
		byte_count_d  = byte_count_q;
		large_d       = large_q;
		expected_d    = expected_q;
		got_number_d  = got_number_q;
		got_compl_d   = got_compl_q;
		crc_d         = crc_q;
		crc_hi_d      = crc_hi_q;
		next_addr_d   = next_addr_q;
		error_count_d = error_count_q;
		first_seen_d  = first_seen_q;
		session_d     = session_q;
		res           = '0;
		cancel        = 1'b0;
		err           = 1'b0;
		pkt_good      = (got_number_q == expected_q) && (num_sum == 9'd255) &&
		                ({crc_hi_q, byte_s1} == crc_q);

		if (cmd_s1 == CMD_RESTART) begin
			// back to reset values, base address picked up here
			phase_d       = PH_HEADER;
			byte_count_d  = '0;
			large_d       = 1'b0;
			expected_d    = 8'd1;
			got_number_d  = '0;
			got_compl_d   = '0;
			crc_d         = '0;
			crc_hi_d      = '0;
			next_addr_d   = ADDR_WIDTH'(base_address_q);
			error_count_d = '0;
			first_seen_d  = 1'b0;
			session_d     = SES_RUN;
		end else if (cmd_s1 != CMD_BYTE && cmd_s1 != CMD_TIMEOUT) begin
			// unused command: no reply
		end else if (session_q != SES_RUN) begin
			// session over: only restart resumes
		end else if (cmd_s1 == CMD_TIMEOUT) begin
			if (phase_q == PH_HEADER) begin
				if (!first_seen_q) begin
					res.reply_valid = 1'b1;
					res.reply_byte  = B_C;
				end else begin
					err = 1'b1;
				end
			end else begin
				// timeout inside a packet ends it as bad
				res.packet_done = 1'b1;
				phase_d         = PH_HEADER;
				err             = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (byte_s1 == B_SOH || byte_s1 == B_STX) begin
						large_d      = (byte_s1 == B_STX);
						byte_count_d = '0;
						crc_d        = '0;
						phase_d      = PH_NUMBER;
					end else if (byte_s1 == B_EOT) begin
						res.reply_valid = 1'b1;
						res.reply_byte  = B_ACK;
						session_d       = SES_DONE;
					end else if (byte_s1 == B_CAN || byte_s1 == B_ETX) begin
						session_d = SES_ABORT;
					end else begin
						err = 1'b1;
					end
				end
				PH_NUMBER: begin
					got_number_d = byte_s1;
					phase_d      = PH_COMPL;
				end
				PH_COMPL: begin
					got_compl_d = byte_s1;
					phase_d     = PH_DATA;
				end
				PH_DATA: begin
					res.data_valid = 1'b1;
					res.data_byte  = byte_s1;
					res.data_addr  = next_addr_q + ADDR_WIDTH'(byte_count_q);
					crc_d          = crc_byte(crc_q, byte_s1);
					if (byte_count_q ==
					    (large_q ? 10'(LARGE_SIZE - 1) : 10'(SMALL_SIZE - 1))) begin
						byte_count_d = '0;
						phase_d      = PH_CRC_HI;
					end else begin
						byte_count_d = byte_count_q + 10'd1;
					end
				end
				PH_CRC_HI: begin
					crc_hi_d = byte_s1;
					phase_d  = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					phase_d         = PH_HEADER;
					first_seen_d    = 1'b1;
					res.packet_done = 1'b1;
					res.packet_ok   = pkt_good;
					if (pkt_good) begin
						res.reply_valid = 1'b1;
						res.reply_byte  = B_ACK;
						expected_d      = expected_q + 8'd1;
						next_addr_d     = next_addr_q +
						                  (large_q ? ADDR_WIDTH'(LARGE_SIZE) :
						                             ADDR_WIDTH'(SMALL_SIZE));
					end else begin
						err = 1'b1;
					end
				end
				default: begin
					// unused phase codes fall back to header hunt
					phase_d = PH_HEADER;
				end
			endcase
		end

		// shared error handling: saturating count, NAK or cancel
		if (err) begin
			error_count_d = ec_inc;
			if (ec_inc >= max_errors_q) begin
				cancel    = 1'b1;
				session_d = SES_ABORT;
			end else begin
				res.reply_valid = 1'b1;
				res.reply_byte  = B_NAK;
			end
		end
		if (cancel) begin
			res.reply_valid = 1'b1;
			res.reply_byte  = B_CAN;
		end
		res.session = session_d;
		res.last    = !cancel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			max_errors_q   <= 8'd3;
			valid_s1       <= 1'b0;
			cmd_s1         <= '0;
			byte_s1        <= '0;
			phase_q        <= PH_HEADER;
			byte_count_q   <= '0;
			large_q        <= 1'b0;
			expected_q     <= 8'd1;
			got_number_q   <= '0;
			got_compl_q    <= '0;
			crc_q          <= '0;
			crc_hi_q       <= '0;
			next_addr_q    <= '0;
			error_count_q  <= '0;
			first_seen_q   <= 1'b0;
			session_q      <= SES_RUN;
			out_valid_q    <= 1'b0;
			can2_q         <= 1'b0;
			out_q          <= '0;
		end else begin
			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BASE_ADDR:  base_address_q <= cfg_data;
					REG_MAX_ERRORS: max_errors_q   <= cfg_data[7:0];
					default:        ;
				endcase
			end

			// input register
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
				cmd_s1   <= cmd;
				byte_s1  <= rx_byte;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			// state update on each processed word
			if (fire) begin
				phase_q       <= phase_d;
				byte_count_q  <= byte_count_d;
				large_q       <= large_d;
				expected_q    <= expected_d;
				got_number_q  <= got_number_d;
				got_compl_q   <= got_compl_d;
				crc_q         <= crc_d;
				crc_hi_q      <= crc_hi_d;
				next_addr_q   <= next_addr_d;
				error_count_q <= error_count_d;
				first_seen_q  <= first_seen_d;
				session_q     <= session_d;
			end

			// result register: second CAN word first, then new results
			if (out_valid_q && out_ready && can2_q) begin
				out_q  <= can2_word;
				can2_q <= 1'b0;
			end else if (fire) begin
				out_q       <= res;
				out_valid_q <= 1'b1;
				can2_q      <= cancel;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign reply_valid = out_q.reply_valid;
	assign reply_byte  = out_q.reply_byte;
	assign data_valid  = out_q.data_valid;
	assign data_byte   = out_q.data_byte;
	assign data_addr   = out_q.data_addr;
	assign packet_done = out_q.packet_done;
	assign packet_ok   = out_q.packet_ok;
	assign session     = out_q.session;
	assign last        = out_q.last;

endmodule

`default_nettype wire

@@ sv/xcr_checker.sv @@
// port-level checker for the xmodem crc receiver, bound to the top level
`default_nettype none

`include "xmodem_crc_receiver_assert.svh"

module xcr_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic                      reply_valid,
	input wire logic [7:0]                reply_byte,
	input wire logic                      data_valid,
	input wire logic [xcr_pkg::ADDR_WIDTH-1:0] data_addr,
	input wire logic                      packet_done,
	input wire logic                      packet_ok,
	input wire logic [1:0]                session,
	input wire logic                      last
);
	import xcr_pkg::*;

	// stalled result word holds
	`XCR_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(reply_byte) && $stable(data_addr) && $stable(last))
	// first word of a cancel is followed by the closing CAN word
	`XCR_ASSERT_NXT(a_can_pair, out_valid && out_ready && !last, out_valid && reply_valid && reply_byte == B_CAN && last)
	// a non-final word only comes from a cancel
	`XCR_ASSERT_IMP(a_not_last, out_valid && !last, reply_valid && reply_byte == B_CAN && session == SES_ABORT)
	// a good packet ends with ACK
	`XCR_ASSERT_IMP(a_pkt_ok, out_valid && packet_ok, packet_done && reply_valid && reply_byte == B_ACK)
	// payload words carry no reply and no verdict
	`XCR_ASSERT_IMP(a_data, out_valid && data_valid, !reply_valid && !packet_done)

endmodule

bind xmodem_crc_receiver xcr_checker u_xcr_checker (.*);

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the xmodem crc receiver: directed table, then random sessions
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import xcr_pkg::*;

	// the fourth command code has no meaning and must be ignored
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_HEADER, ST_NUMBER, ST_COMPL, ST_DATA, ST_CRC_HI, ST_CRC_LO
	} rx_phase_t;

	typedef enum {PK_GOOD, PK_BAD_NUM, PK_BAD_COMPL, PK_BAD_CRC, PK_CUT} pkt_fault_t;

	// one result word, fields in port order
	typedef struct packed {
		logic                  rv;
		logic [7:0]            rb;
		logic                  dv;
		logic [7:0]            db;
		logic [ADDR_WIDTH-1:0] da;
		logic                  pd;
		logic                  pk;
		logic [1:0]            ses;
		logic                  lst;
	} answer_t;

	// directed stimulus row; fixed rows carry the answer typed in (data fields are zero)
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] b;
		logic       fixed;
		logic       rv;
		logic [7:0] rb;
		logic       pd;
		logic       pk;
		logic [1:0] ses;
		logic       lst;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            cmd = CMD_BYTE;
	logic [7:0]            rx_byte = 8'h00;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_BASE_ADDR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  reply_valid;
	logic [7:0]            reply_byte;
	logic                  data_valid;
	logic [7:0]            data_byte;
	logic [ADDR_WIDTH-1:0] data_addr;
	logic                  packet_done;
	logic                  packet_ok;
	logic [1:0]            session;
	logic                  last;

	xmodem_crc_receiver dut (.*);

	// predicted receiver state
	rx_phase_t             p_phase;
	logic [9:0]            p_count;
	logic                  p_large;
	logic [7:0]            p_exp_num;
	logic [7:0]            p_num;
	logic [7:0]            p_compl;
	logic [15:0]           p_crc;
	logic [7:0]            p_crc_hi;
	logic [ADDR_WIDTH-1:0] p_next_addr;
	logic [7:0]            p_errors;
	logic                  p_seen;
	logic [1:0]            p_session;
	// register copies
	logic [31:0]           c_base;
	logic [7:0]            c_max_err;

	answer_t answers_due[$];
	int      mismatch_count = 0;
	int      items_left = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;

	int      send_pct_tab[3] = '{25, 59, 0};
	int      recv_pct_tab[3] = '{59, 25, 0};
	logic [31:0] base_tab[3] = '{32'hFFFF_FF80, 32'hFFFF_FFFF, 32'h0000_0000};
	logic [7:0]  max_tab[3]  = '{8'd255, 8'd1, 8'd0};

	// header cases, timeouts, aborts and restarts under the reset register values
	dir_row_t dir_rows[27] = '{
		// timeout before any packet asks for crc mode
		'{CMD_TIMEOUT, 8'h00, 1'b1, 1'b1, B_C,   1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_NONE,    8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		// unknown header bytes count as errors
		'{CMD_BYTE,    8'h00, 1'b1, 1'b1, B_NAK, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'hFF, 1'b1, 1'b1, B_NAK, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    B_SOH, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'hFE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'h5A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b0},
		// timeout inside the packet is the third error: CAN CAN
		'{CMD_TIMEOUT, 8'hFF, 1'b1, 1'b1, B_CAN, 1'b1, 1'b0, SES_ABORT, 1'b0},
		// aborted session ignores bytes and timeouts
		'{CMD_BYTE,    B_SOH, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_ABORT, 1'b1},
		'{CMD_TIMEOUT, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_ABORT, 1'b1},
		'{CMD_RESTART, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'h80, 1'b1, 1'b1, B_NAK, 1'b0, 1'b0, SES_RUN,   1'b1},
		// end of transfer
		'{CMD_BYTE,    B_EOT, 1'b1, 1'b1, B_ACK, 1'b0, 1'b0, SES_DONE,  1'b1},
		'{CMD_BYTE,    8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_DONE,  1'b1},
		'{CMD_RESTART, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		// cancel and ctrl-c as a header abort silently
		'{CMD_BYTE,    B_CAN, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_ABORT, 1'b1},
		'{CMD_RESTART, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    B_ETX, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_ABORT, 1'b1},
		'{CMD_RESTART, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		// start of a 1k packet, cut short by a timeout
		'{CMD_BYTE,    B_STX, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b1},
		'{CMD_BYTE,    8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b0},
		'{CMD_BYTE,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, SES_RUN,   1'b0},
		'{CMD_TIMEOUT, 8'h55, 1'b1, 1'b1, B_NAK, 1'b1, 1'b0, SES_RUN,   1'b1},
		// a cut packet does not count as seen: still asking for crc mode
		'{CMD_TIMEOUT, 8'h00, 1'b1, 1'b1, B_C,   1'b0, 1'b0, SES_RUN,   1'b1}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// crc-16 ccitt, one data bit at a time, msb first
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void session_reset();
		p_phase = ST_HEADER;
		p_count = '0;
		p_large = 1'b0;
		p_exp_num = 8'd1;
		p_num = '0;
		p_compl = '0;
		p_crc = '0;
		p_crc_hi = '0;
		p_next_addr = c_base[ADDR_WIDTH-1:0];
		p_errors = '0;
		p_seen = 1'b0;
		p_session = SES_RUN;
	endfunction

	// count one error, saturating; true when the transfer has to be cancelled
	function automatic logic note_error(inout answer_t a);
		if (p_errors != 8'hFF) begin
			p_errors = p_errors + 8'd1;
		end
		if (p_errors >= c_max_err) begin
			p_session = SES_ABORT;
			return 1'b1;
		end
		a.rv = 1'b1;
		a.rb = B_NAK;
		return 1'b0;
	endfunction

	// advance the predicted receiver by one input word; returns the number of result words
	function automatic int compute_answers(input logic [1:0] c, input logic [7:0] b,
			output answer_t first, output answer_t second);
		answer_t               a;
		logic                  cancel;
		logic                  good;
		logic [ADDR_WIDTH-1:0] size;
		a = '0;
		second = '0;
		cancel = 1'b0;
		size = p_large ? ADDR_WIDTH'(LARGE_SIZE) : ADDR_WIDTH'(SMALL_SIZE);
		if (c == CMD_RESTART) begin
			session_reset();
		end else if (c == CMD_NONE || p_session != SES_RUN) begin
			// ignored word: no reply, state untouched
		end else if (c == CMD_TIMEOUT) begin
			if (p_phase != ST_HEADER) begin
				// packet cut short
				a.pd = 1'b1;
				p_phase = ST_HEADER;
				cancel = note_error(a);
			end else if (!p_seen) begin
				a.rv = 1'b1;
				a.rb = B_C;
			end else begin
				cancel = note_error(a);
			end
		end else begin
			case (p_phase)
				ST_HEADER: begin
					if (b == B_SOH || b == B_STX) begin
						p_large = (b == B_STX);
						p_count = '0;
						p_crc = '0;
						p_phase = ST_NUMBER;
					end else if (b == B_EOT) begin
						a.rv = 1'b1;
						a.rb = B_ACK;
						p_session = SES_DONE;
					end else if (b == B_CAN || b == B_ETX) begin
						p_session = SES_ABORT;
					end else begin
						cancel = note_error(a);
					end
				end
				ST_NUMBER: begin
					p_num = b;
					p_phase = ST_COMPL;
				end
				ST_COMPL: begin
					p_compl = b;
					p_phase = ST_DATA;
				end
				ST_DATA: begin
					a.dv = 1'b1;
					a.db = b;
					a.da = p_next_addr + ADDR_WIDTH'(p_count);
					p_crc = crc16_step(p_crc, b);
					if (p_count + 1 >= size) begin
						p_count = '0;
						p_phase = ST_CRC_HI;
					end else begin
						p_count = p_count + 10'd1;
					end
				end
				ST_CRC_HI: begin
					p_crc_hi = b;
					p_phase = ST_CRC_LO;
				end
				default: begin
					good = (p_num == p_exp_num) &&
						({1'b0, p_num} + {1'b0, p_compl} == 9'd255) &&
						({p_crc_hi, b} == p_crc);
					p_phase = ST_HEADER;
					p_seen = 1'b1;
					a.pd = 1'b1;
					a.pk = good;
					if (good) begin
						a.rv = 1'b1;
						a.rb = B_ACK;
						p_exp_num = p_exp_num + 8'd1;
						p_next_addr = p_next_addr + size;
					end else begin
						cancel = note_error(a);
					end
				end
			endcase
		end
		if (cancel) begin
			a.rv = 1'b1;
			a.rb = B_CAN;
		end
		a.ses = p_session;
		a.lst = !cancel;
		first = a;
		if (cancel) begin
			// second CAN of the pair
			second.rv = 1'b1;
			second.rb = B_CAN;
			second.ses = p_session;
			second.lst = 1'b1;
			return 2;
		end
		return 1;
	endfunction

	function automatic string show(input answer_t a);
		return $sformatf("rv=%0d rb=%02h dv=%0d db=%02h da=%08h pd=%0d pk=%0d ses=%0d last=%0d",
			a.rv, a.rb, a.dv, a.db, a.da, a.pd, a.pk, a.ses, a.lst);
	endfunction

	// random idling at the given percentage
	function automatic logic idle_now(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// receiver side: random back-pressure on the result channel
	always @(posedge clk) begin
		out_ready <= !idle_now(recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin : check_results
		answer_t got;
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {reply_valid, reply_byte, data_valid, data_byte, data_addr,
				packet_done, packet_ok, session, last};
			if (answers_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected word: %s", show(got));
				end
			end else begin
				want = answers_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected %s", show(want));
						$display("          actual   %s", show(got));
					end
				end
			end
		end
	end

	// present one word and hold it until the block takes it
	task automatic drive_word(input logic [1:0] c, input logic [7:0] b);
		while (idle_now(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_word(input logic [1:0] c, input logic [7:0] b);
		answer_t a0;
		answer_t a1;
		int      n;
		n = compute_answers(c, b, a0, a1);
		answers_due.push_back(a0);
		if (n == 2) begin
			answers_due.push_back(a1);
		end
		items_left--;
		drive_word(c, b);
	endtask

	// block idle: every predicted word delivered, then the pipeline left to settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == REG_BASE_ADDR) begin
			c_base = value;
		end else begin
			c_max_err = value[7:0];
		end
	endtask

	// new random register setting, extremes favored
	task automatic retune();
		logic [31:0] base;
		logic [7:0]  max_err;
		case ($urandom_range(3))
			0: base = 32'h0000_0000;
			1: base = 32'hFFFF_FFFF;
			2: base = 32'hFFFF_FF80;
			default: base = $urandom;
		endcase
		case ($urandom_range(5))
			0: max_err = 8'd0;
			1: max_err = 8'd1;
			2: max_err = 8'd3;
			3: max_err = 8'd255;
			default: max_err = 8'($urandom_range(254, 2));
		endcase
		write_reg(REG_BASE_ADDR, base);
		write_reg(REG_MAX_ERRORS, {24'h0, max_err});
	endtask

	// one framed packet, correct or with one fault
	task automatic send_packet(input logic big, input pkt_fault_t fault);
		logic [7:0]  frame[$];
		logic [7:0]  num;
		logic [7:0]  cpl;
		logic [7:0]  d;
		logic [15:0] crc;
		int          n;
		int          cut;
		int          fill;
		n = big ? LARGE_SIZE : SMALL_SIZE;
		num = p_exp_num;
		if (fault == PK_BAD_NUM) begin
			num = num + 8'($urandom_range(255, 1));
		end
		cpl = ~num;
		if (fault == PK_BAD_COMPL) begin
			cpl = cpl ^ 8'($urandom_range(255, 1));
		end
		frame.push_back(big ? B_STX : B_SOH);
		frame.push_back(num);
		frame.push_back(cpl);
		crc = '0;
		fill = $urandom_range(7);
		for (int i = 0; i < n; i++) begin
			d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
			crc = crc16_step(crc, d);
			frame.push_back(d);
		end
		if (fault == PK_BAD_CRC) begin
			crc = crc ^ 16'($urandom_range(65535, 1));
		end
		frame.push_back(crc[15:8]);
		frame.push_back(crc[7:0]);
		// a cut packet stops early; 1k ones only a little way in
		cut = frame.size();
		if (fault == PK_CUT) begin
			cut = $urandom_range(big ? 40 : n + 2, 1);
		end
		for (int i = 0; i < cut; i++) begin
			// stray unused command inside the packet must not disturb it
			if ($urandom_range(99) == 0) begin
				send_word(CMD_NONE, 8'($urandom));
			end
			send_word(CMD_BYTE, frame[i]);
		end
		if (fault == PK_CUT) begin
			send_word(($urandom_range(3) == 0) ? CMD_RESTART : CMD_TIMEOUT, 8'($urandom));
		end
	endtask

	// restart, then a random mix of packets and header events until the session stops or no items are left
	task automatic run_session();
		int         pick;
		int         fpick;
		pkt_fault_t fault;
		send_word(CMD_RESTART, 8'($urandom));
		while (p_session == SES_RUN && items_left > 0) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				fpick = $urandom_range(99);
				if (fpick < 60) begin
					fault = PK_GOOD;
				end else if (fpick < 70) begin
					fault = PK_BAD_NUM;
				end else if (fpick < 78) begin
					fault = PK_BAD_COMPL;
				end else if (fpick < 88) begin
					fault = PK_BAD_CRC;
				end else begin
					fault = PK_CUT;
				end
				send_packet(fault == PK_CUT && $urandom_range(3) == 0, fault);
			end else if (pick < 80) begin
				send_word(CMD_TIMEOUT, 8'($urandom));
			end else if (pick < 88) begin
				// noise at the header, may start a packet by chance
				send_word(CMD_BYTE, 8'($urandom));
			end else if (pick < 91) begin
				send_word(CMD_NONE, 8'($urandom));
			end else if (pick < 95) begin
				send_word(CMD_BYTE, B_EOT);
			end else if (pick < 97) begin
				send_word(CMD_BYTE, $urandom_range(1) ? B_CAN : B_ETX);
			end else begin
				send_word(CMD_RESTART, 8'($urandom));
			end
		end
		// a stopped session swallows everything but a restart
		if (p_session != SES_RUN) begin
			repeat ($urandom_range(3)) begin
				send_word($urandom_range(1) ? CMD_BYTE : CMD_TIMEOUT, 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		answer_t a0;
		answer_t a1;
		int      n;
		int      waited;
		c_base = '0;
		c_max_err = 8'd3;
		session_reset();
		send_idle_pct = send_pct_tab[0];
		recv_idle_pct = recv_pct_tab[0];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset register values
		foreach (dir_rows[i]) begin
			n = compute_answers(dir_rows[i].cmd, dir_rows[i].b, a0, a1);
			if (dir_rows[i].fixed) begin
				a0 = '0;
				a0.rv = dir_rows[i].rv;
				a0.rb = dir_rows[i].rb;
				a0.pd = dir_rows[i].pd;
				a0.pk = dir_rows[i].pk;
				a0.ses = dir_rows[i].ses;
				a0.lst = dir_rows[i].lst;
				a1 = '0;
				a1.rv = 1'b1;
				a1.rb = B_CAN;
				a1.ses = dir_rows[i].ses;
				a1.lst = 1'b1;
				n = dir_rows[i].lst ? 1 : 2;
			end
			answers_due.push_back(a0);
			if (n == 2) begin
				answers_due.push_back(a1);
			end
			drive_word(dir_rows[i].cmd, dir_rows[i].b);
		end

		// random part: three idling profiles, each opening with an extreme setting
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pct_tab[ph];
			recv_idle_pct = recv_pct_tab[ph];
			write_reg(REG_BASE_ADDR, base_tab[ph]);
			write_reg(REG_MAX_ERRORS, {24'h0, max_tab[ph]});
			items_left = 100;
			while (items_left > 0) begin
				if ($urandom_range(99) < 30) begin
					retune();
				end
				run_session();
			end
		end

		// drain
		in_valid <= 1'b0;
		waited = 0;
		while (answers_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		// anything still owed by the block is a failure
		mismatch_count += answers_due.size();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/xcr_pkg.sv
sv/xmodem_crc_receiver.sv
sv/xcr_checker.sv
sim/tb_top.sv
